FILE: hw/rtl/lsfe_pkg.sv
package lsfe_pkg;

  // Field widths
  localparam int OP_W     = 2;
  localparam int LEVEL_W  = 8;
  localparam int CH_W     = 2;
  localparam int STRIP_W  = 2;
  localparam int WORD_W   = 32;
  localparam int REP_W    = 8;
  localparam int COUNT_W  = 12;
  localparam int SCOUNT_W = 3;
  localparam int BRIGHT_W = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP0_LEDS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP1_LEDS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP2_LEDS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP3_LEDS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAILER_WORDS = 3'd6;

  // Register values after reset
  localparam logic [SCOUNT_W-1:0] RST_STRIP_COUNT   = 3'd2;
  localparam logic [COUNT_W-1:0]  RST_STRIP0_LEDS   = 12'd600;
  localparam logic [COUNT_W-1:0]  RST_STRIP1_LEDS   = 12'd541;
  localparam logic [COUNT_W-1:0]  RST_STRIP2_LEDS   = 12'd0;
  localparam logic [COUNT_W-1:0]  RST_STRIP3_LEDS   = 12'd0;
  localparam logic [BRIGHT_W-1:0] RST_BRIGHTNESS    = 5'd31;
  localparam logic [REP_W-1:0]    RST_TRAILER_WORDS = 8'd75;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_PIXEL = 2'd1;
  localparam logic [OP_W-1:0] OP_END   = 2'd2;

  // Gamma table selectors
  localparam logic [CH_W-1:0] CH_RED   = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;
  localparam logic [CH_W-1:0] CH_NONE  = 2'd3;

  // Strip limits and gamma storage
  localparam logic [SCOUNT_W-1:0] MAX_STRIPS = 3'd4;
  localparam int GAMMA_DEPTH   = 256;
  localparam int GAMMA_ENTRIES = 3 * GAMMA_DEPTH;
  localparam int GAMMA_AW      = CH_W + LEVEL_W;

  // Upper three bits of every pixel header byte
  localparam logic [2:0] HEADER_MARK = 3'b111;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic               last_in_message;
    logic [CH_W-1:0]    load_channel;
    logic [LEVEL_W-1:0] load_index;
    logic [LEVEL_W-1:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [STRIP_W-1:0] strip;
    logic [WORD_W-1:0]  word;
    logic [REP_W-1:0]   repeat_res;
    logic               end_of_transfer;
    logic               last;
  } out_item_t;

endpackage

FILE: hw/rtl/lsfe_stream_if.sv
// Valid/ready channel carrying one payload beat per handshake.
interface lsfe_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

FILE: hw/rtl/led_strip_frame_encoder_top.sv
// LED strip frame encoder. Input beats are gamma loads, pixels or end-of-message
// markers; output beats are 32-bit frame words tagged with their strip, a repeat
// count (above one only on trailers), an end-of-transfer flag and a flag on the
// last word caused by an input beat. A pixel may cause start or trailer words
// around its pixel word; a pixel that ends the message is followed by the
// closing sequence, and a pixel that arrives when every strip is full is
// dropped. An end-of-message beat causes the closing sequence alone.
// Back-pressure on the output stalls the sequencer. The gamma memory is read
// three times per pixel, and the sequencer produces at most one frame word per
// cycle, and none while the pending word cannot move on. The output register
// lets the next input beat be accepted while the last word still waits. The
// gamma memory has no reset: load every entry before pixels use it.
module led_strip_frame_encoder_top (
  input  logic                              clk,
  input  logic                              rst_n,
  lsfe_stream_if.sink                       in_ch,
  lsfe_stream_if.source                     out_ch,
  input  logic                              cfg_we,
  input  logic [lsfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsfe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import lsfe_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BOUND = 6'b000010,
    S_WALK  = 6'b000100,
    S_TAIL  = 6'b001000,
    S_FIN   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    RD_IDLE  = 4'b0001,
    RD_GREEN = 4'b0010,
    RD_BLUE  = 4'b0100,
    RD_DONE  = 4'b1000
  } rd_step_t;

  // Configuration registers
  logic [SCOUNT_W-1:0] strip_count_r;
  logic [COUNT_W-1:0]  leds_r [MAX_STRIPS];
  logic [BRIGHT_W-1:0] brightness_r;
  logic [REP_W-1:0]    trailer_r;

  // Sequencer state
  state_t              state_r, state_nxt;
  logic [STRIP_W-1:0]  cur_r, cur_nxt;
  logic                open_r, open_nxt;
  logic [COUNT_W-1:0]  ps_r, ps_nxt;
  logic                exh_r, exh_nxt;
  logic                fin_r, fin_nxt;
  logic                last_r, last_nxt;

  // Gamma read sequence
  rd_step_t            rd_step_r, rd_step_nxt;
  logic [LEVEL_W-1:0]  px_green_r, px_blue_r;
  logic [LEVEL_W-1:0]  gam_red_r, gam_red_nxt;
  logic [LEVEL_W-1:0]  gam_green_r, gam_green_nxt;

  // Gamma memory
  logic [LEVEL_W-1:0]  gamma_mem [GAMMA_ENTRIES];
  logic [LEVEL_W-1:0]  mem_rdata_r;
  logic                mem_we, mem_re;
  logic [GAMMA_AW-1:0] mem_waddr, mem_raddr;

  // Pending word and output register
  out_item_t           pend_r, pend_nxt;
  logic                pend_v_r, pend_v_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic                out_v_r, out_v_nxt;

  // Decoded helpers
  in_item_t            in_item;
  logic                in_acc;
  logic [SCOUNT_W-1:0] active;
  logic [COUNT_W-1:0]  leds_cur;
  logic                full_cur, beyond, at_last;
  logic [REP_W-1:0]    trailer_rep;
  logic                out_free, gen_ok;
  logic                do_open, do_close, do_pixel, flush;
  out_item_t           emit_item;

  assign in_item      = in_ch.data;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_data_r;

  // Strip count clamped to the supported range
  always_comb begin
    if (strip_count_r == '0) begin
      active = SCOUNT_W'(1);
    end else if (strip_count_r > MAX_STRIPS) begin
      active = MAX_STRIPS;
    end else begin
      active = strip_count_r;
    end
  end

  assign leds_cur    = leds_r[cur_r];
  assign full_cur    = (ps_r >= leds_cur);
  assign beyond      = ({1'b0, cur_r} >= active);
  assign at_last     = (({1'b0, cur_r} + SCOUNT_W'(1)) >= active);
  assign trailer_rep = (trailer_r == '0) ? REP_W'(1) : trailer_r;
  assign out_free    = !out_v_r || out_ch.ready;
  assign gen_ok      = !pend_v_r || out_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_count_r <= RST_STRIP_COUNT;
      leds_r[0]     <= RST_STRIP0_LEDS;
      leds_r[1]     <= RST_STRIP1_LEDS;
      leds_r[2]     <= RST_STRIP2_LEDS;
      leds_r[3]     <= RST_STRIP3_LEDS;
      brightness_r  <= RST_BRIGHTNESS;
      trailer_r     <= RST_TRAILER_WORDS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STRIP_COUNT:   strip_count_r <= cfg_data[SCOUNT_W-1:0];
        CFG_STRIP0_LEDS:   leds_r[0]     <= cfg_data[COUNT_W-1:0];
        CFG_STRIP1_LEDS:   leds_r[1]     <= cfg_data[COUNT_W-1:0];
        CFG_STRIP2_LEDS:   leds_r[2]     <= cfg_data[COUNT_W-1:0];
        CFG_STRIP3_LEDS:   leds_r[3]     <= cfg_data[COUNT_W-1:0];
        CFG_BRIGHTNESS:    brightness_r  <= cfg_data[BRIGHT_W-1:0];
        CFG_TRAILER_WORDS: trailer_r     <= cfg_data[REP_W-1:0];
        default: ;
      endcase
    end
  end

  // Gamma memory: one port, a write for loads and a registered read for pixels
  assign mem_we    = in_acc && (in_item.operation == OP_LOAD)
                     && (in_item.load_channel != CH_NONE);
  assign mem_waddr = {in_item.load_channel, in_item.load_index};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      gamma_mem[mem_waddr] <= in_item.load_value;
    end
    if (mem_re) begin
      mem_rdata_r <= gamma_mem[mem_raddr];
    end
  end

  // Sequencer: at most one frame word per cycle
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    open_nxt      = open_r;
    ps_nxt        = ps_r;
    exh_nxt       = exh_r;
    fin_nxt       = fin_r;
    last_nxt      = last_r;
    rd_step_nxt   = rd_step_r;
    gam_red_nxt   = gam_red_r;
    gam_green_nxt = gam_green_r;
    mem_re        = 1'b0;
    mem_raddr     = {CH_RED, in_item.red};
    do_open       = 1'b0;
    do_close      = 1'b0;
    do_pixel      = 1'b0;
    flush         = 1'b0;

    // Remaining gamma reads of the current pixel
    case (rd_step_r)
      RD_GREEN: begin
        mem_re      = 1'b1;
        mem_raddr   = {CH_GREEN, px_green_r};
        gam_red_nxt = mem_rdata_r;
        rd_step_nxt = RD_BLUE;
      end
      RD_BLUE: begin
        mem_re        = 1'b1;
        mem_raddr     = {CH_BLUE, px_blue_r};
        gam_green_nxt = mem_rdata_r;
        rd_step_nxt   = RD_DONE;
      end
      default: ;
    endcase

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_item.operation)
            OP_PIXEL: begin
              mem_re      = 1'b1;
              mem_raddr   = {CH_RED, in_item.red};
              rd_step_nxt = RD_GREEN;
              fin_nxt     = 1'b0;
              last_nxt    = in_item.last_in_message;
              state_nxt   = S_BOUND;
            end
            OP_END: begin
              fin_nxt   = 1'b1;
              last_nxt  = 1'b1;
              state_nxt = S_BOUND;
            end
            default: ;
          endcase
        end
      end
      S_BOUND: begin
        // A strip index past the strip count means all strips are full
        if (!exh_r && beyond) begin
          exh_nxt  = 1'b1;
          open_nxt = 1'b0;
        end
        state_nxt = fin_r ? S_FIN : S_WALK;
      end
      S_WALK: begin
        if (exh_r) begin
          state_nxt = last_r ? S_FIN : S_DONE;
        end else if (!open_r || full_cur) begin
          if (gen_ok) begin
            do_close = open_r;
            do_open  = !open_r;
          end
        end else if (gen_ok && (rd_step_r == RD_DONE)) begin
          do_pixel  = 1'b1;
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        if (full_cur) begin
          if (gen_ok) begin
            do_close  = 1'b1;
            state_nxt = last_r ? S_FIN : S_DONE;
          end
        end else begin
          state_nxt = last_r ? S_FIN : S_DONE;
        end
      end
      S_FIN: begin
        // Serve every strip left, then rearm for the next message
        if (exh_r) begin
          cur_nxt   = '0;
          open_nxt  = 1'b0;
          ps_nxt    = '0;
          exh_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (gen_ok) begin
          do_close = open_r;
          do_open  = !open_r;
        end
      end
      S_DONE: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          flush     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Strip bookkeeping for the word produced this cycle
    if (do_open) begin
      open_nxt = 1'b1;
      ps_nxt   = '0;
    end
    if (do_close) begin
      open_nxt = 1'b0;
      ps_nxt   = '0;
      if (at_last) begin
        exh_nxt = 1'b1;
      end else begin
        cur_nxt = cur_r + STRIP_W'(1);
      end
    end
    if (do_pixel) begin
      ps_nxt = ps_r + COUNT_W'(1);
    end
  end

  // Word produced this cycle
  always_comb begin
    emit_item.strip           = cur_r;
    emit_item.word            = '0;
    emit_item.repeat_res      = REP_W'(1);
    emit_item.end_of_transfer = 1'b0;
    emit_item.last            = 1'b0;
    if (do_close) begin
      emit_item.repeat_res      = trailer_rep;
      emit_item.end_of_transfer = 1'b1;
    end
    if (do_pixel) begin
      emit_item.word = {HEADER_MARK, brightness_r, mem_rdata_r, gam_green_r, gam_red_r};
    end
  end

  // A word waits in the pending slot until the next one shows it was not the last
  always_comb begin
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    out_data_nxt = out_data_r;
    out_v_nxt    = out_v_r && !out_ch.ready;
    if (do_open || do_close || do_pixel) begin
      pend_nxt   = emit_item;
      pend_v_nxt = 1'b1;
      if (pend_v_r) begin
        out_data_nxt      = pend_r;
        out_data_nxt.last = 1'b0;
        out_v_nxt         = 1'b1;
      end
    end
    if (flush) begin
      out_data_nxt      = pend_r;
      out_data_nxt.last = 1'b1;
      out_v_nxt         = 1'b1;
      pend_v_nxt        = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cur_r     <= '0;
      open_r    <= 1'b0;
      ps_r      <= '0;
      exh_r     <= 1'b0;
      fin_r     <= 1'b0;
      last_r    <= 1'b0;
      rd_step_r <= RD_IDLE;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_r     <= cur_nxt;
      open_r    <= open_nxt;
      ps_r      <= ps_nxt;
      exh_r     <= exh_nxt;
      fin_r     <= fin_nxt;
      last_r    <= last_nxt;
      rd_step_r <= rd_step_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_green_r <= in_item.green;
      px_blue_r  <= in_item.blue;
    end
    gam_red_r   <= gam_red_nxt;
    gam_green_r <= gam_green_nxt;
    pend_r      <= pend_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

FILE: hw/rtl/lsfe_check.sv
// Port-level checks on the frame word output.
module lsfe_check (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input lsfe_pkg::out_item_t out_data
);

  import lsfe_pkg::*;

  // A word that is offered stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat withdrawn before it was taken");

  // Only a trailer is sent more than once, and never zero times.
  a_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.repeat_res == REP_W'(1))
                  || (out_data.end_of_transfer && (out_data.repeat_res != '0)))
    else $error("bad repeat count on output beat");

  // Start and trailer words are zero; a trailer never carries pixel data.
  a_trailer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_of_transfer |-> (out_data.word == '0))
    else $error("trailer word is not zero");

  // Every non-zero word is a pixel word with its header mark.
  a_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.word != '0) |-> (out_data.word[31:29] == HEADER_MARK))
    else $error("pixel word without header mark");

endmodule

bind led_strip_frame_encoder_top lsfe_check u_lsfe_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
